[sv/gab_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gab_pkg: shared types and constants for the grouped average bins block
// Beat layouts, bin table word, divider request/status and function codes.
// ----------------------------------------------------------------------------
package gab_pkg;

    localparam int NUM_BINS    = 2048;
    localparam int BIN_AW      = $clog2(NUM_BINS);
    localparam int BIN_ID_W    = 11;
    localparam int RATING_W    = 4;
    localparam int COUNT_W     = 20;
    localparam int SUM_W       = 24;
    localparam int AVG_W       = 12;
    localparam int FRAC_W      = 8;
    localparam int NUM_W       = SUM_W + FRAC_W;
    localparam int DIV_STEP_W  = $clog2(AVG_W);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [AVG_W-1:0]   AVG_MAX   = {AVG_W{1'b1}};

    typedef enum logic [0:0] {
        FUNC_ADD  = 1'b0,
        FUNC_READ = 1'b1
    } func_t;

    typedef struct packed {
        func_t                func;
        logic [BIN_ID_W-1:0]  bin_id;
        logic [RATING_W-1:0]  rating;
    } in_t;

    typedef struct packed {
        logic [BIN_ID_W-1:0]  read_bin;
        logic [AVG_W-1:0]     average;
        logic [COUNT_W-1:0]   sample_count;
        logic                 nonempty;
        logic                 saturated;
    } out_t;

    typedef struct packed {
        logic [COUNT_W-1:0]   count;
        logic [SUM_W-1:0]     sum;
    } bin_t;

    typedef struct packed {
        logic                 valid;
        logic [BIN_ID_W-1:0]  read_bin;
        logic [COUNT_W-1:0]   bin_cnt;
        logic [SUM_W-1:0]     bin_sum;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
    } div_stat_t;

endpackage
`default_nettype wire

[sv/gab_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gab_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module gab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old word on a same-address write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[sv/gab_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gab_div: bin average divider
// Restoring divide of sum*2^FRAC_W by count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gab_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire gab_pkg::div_req_t req,
    input  wire logic              take,
    output gab_pkg::div_stat_t     stat,
    output gab_pkg::out_t          res
);
    import gab_pkg::*;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    div_state_t              state_reg;
    logic [DIV_STEP_W-1:0]   step_reg;
    logic [COUNT_W-1:0]      rem_reg;
    logic [AVG_W-1:0]        num_reg;
    logic [AVG_W-1:0]        quo_reg;
    logic [COUNT_W-1:0]      cnt_reg;
    logic [BIN_ID_W-1:0]     bin_reg;
    logic                    ovf_reg;

    logic [NUM_W-1:0]        num_start;
    logic [COUNT_W:0]        trial;
    logic [COUNT_W:0]        diff;
    logic                    trial_ge;
    logic [COUNT_W-1:0]      rem_next;

    assign num_start = {req.bin_sum, FRAC_W'(0)};
    assign trial     = {rem_reg, num_reg[AVG_W-1]};
    assign diff      = trial - {1'b0, cnt_reg};
    assign trial_ge  = trial >= {1'b0, cnt_reg};
    assign rem_next  = trial_ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
        end else begin
            unique case (state_reg)
                DIV_IDLE: begin
                    if (req.valid) begin
                        state_reg <= DIV_RUN;
                        step_reg  <= '0;
                        rem_reg   <= num_start[NUM_W-1:AVG_W];
                        num_reg   <= num_start[AVG_W-1:0];
                        quo_reg   <= '0;
                        cnt_reg   <= req.bin_cnt;
                        bin_reg   <= req.read_bin;
                        // quotient would not fit in AVG_W bits
                        ovf_reg   <= num_start[NUM_W-1:AVG_W] >= req.bin_cnt;
                    end
                end
                DIV_RUN: begin
                    rem_reg  <= rem_next;
                    num_reg  <= {num_reg[AVG_W-2:0], 1'b0};
                    quo_reg  <= {quo_reg[AVG_W-2:0], trial_ge};
                    step_reg <= step_reg + DIV_STEP_W'(1);
                    if (step_reg == DIV_STEP_W'(AVG_W - 1)) begin
                        state_reg <= DIV_DONE;
                    end
                end
                DIV_DONE: begin
                    if (take) begin
                        state_reg <= DIV_IDLE;
                    end
                end
                default: state_reg <= DIV_IDLE;
            endcase
        end
    end

    assign stat.busy = state_reg != DIV_IDLE;
    assign stat.done = state_reg == DIV_DONE;

    always_comb begin
        res.read_bin     = bin_reg;
        res.sample_count = cnt_reg;
        res.nonempty     = cnt_reg != '0;
        res.saturated    = cnt_reg == COUNT_MAX;
        if (cnt_reg == '0) begin
            res.average = '0;
        end else if (ovf_reg) begin
            res.average = AVG_MAX;
        end else begin
            res.average = quo_reg;
        end
    end

endmodule
`default_nettype wire

[sv/grouped_average_bins.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grouped_average_bins: per-key sample count and sum, averaged on read
// Bin table in one RAM; adds are read-modify-write with write forwarding.
// ----------------------------------------------------------------------------
// Add beats: one per cycle while s_ready is high, two-stage read-modify-write through the bin RAM.
// Read beats: the result comes from the 12-bit serial divider through the output register;
//   no beat is taken while a read sits in stage 1 or the divider is busy.
// Reset: a clearing pass writes every bin to zero, with s_ready low;
//   m_valid is low out of reset.
module grouped_average_bins (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire gab_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output gab_pkg::out_t      m_data
);
    import gab_pkg::*;

    logic                    clr_active_reg;
    logic [BIN_AW-1:0]       clr_addr_reg;

    logic                    s1_valid_reg;
    func_t                   s1_func_reg;
    logic [BIN_ID_W-1:0]     s1_bin_reg;
    logic [RATING_W-1:0]     s1_rating_reg;
    logic                    s1_hit_reg;

    logic                    fwd_we_reg;
    logic [BIN_AW-1:0]       fwd_addr_reg;
    bin_t                    fwd_data_reg;

    logic                    m_valid_reg;
    out_t                    m_data_reg;

    logic                    s_accept;
    logic [BIN_AW-1:0]       s1_addr;
    logic                    ram_we;
    logic [BIN_AW-1:0]       ram_waddr;
    bin_t                    ram_wdata;
    logic [$bits(bin_t)-1:0] ram_rdata;
    bin_t                    bin_cur;
    logic                    add_ok;

    div_req_t                div_req;
    div_stat_t               div_stat;
    out_t                    div_res;
    logic                    div_take;

    assign s_ready  = !clr_active_reg && !div_stat.busy
                   && !(s1_valid_reg && s1_func_reg == FUNC_READ);
    assign s_accept = s_valid && s_ready;
    assign s1_addr  = BIN_AW'(s1_bin_reg);

    // last cycle's write has not reached the RAM read yet
    assign bin_cur = (fwd_we_reg && fwd_addr_reg == s1_addr) ? fwd_data_reg
                                                              : bin_t'(ram_rdata);

    assign add_ok = s1_valid_reg && s1_func_reg == FUNC_ADD && s1_hit_reg
                 && bin_cur.count != COUNT_MAX;

    always_comb begin
        if (clr_active_reg) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else begin
            ram_we          = add_ok;
            ram_waddr       = s1_addr;
            ram_wdata.count = bin_cur.count + COUNT_W'(1);
            ram_wdata.sum   = bin_cur.sum + SUM_W'(s1_rating_reg);
        end
    end

    gab_ram #(
        .WIDTH ($bits(bin_t)),
        .DEPTH (NUM_BINS)
    ) u_bin_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (BIN_AW'(s_data.bin_id)),
        .rdata (ram_rdata)
    );

    always_comb begin
        div_req.valid    = s1_valid_reg && s1_func_reg == FUNC_READ;
        div_req.read_bin = s1_bin_reg;
        div_req.bin_cnt  = s1_hit_reg ? bin_cur.count : '0;
        div_req.bin_sum  = s1_hit_reg ? bin_cur.sum : '0;
    end

    assign div_take = div_stat.done && (!m_valid_reg || m_ready);

    gab_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .take    (div_take),
        .stat    (div_stat),
        .res     (div_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + BIN_AW'(1);
            if (clr_addr_reg == BIN_AW'(NUM_BINS - 1)) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_we_reg   <= 1'b0;
        end else begin
            s1_valid_reg <= s_accept;
            fwd_we_reg   <= ram_we;
        end
        if (s_accept) begin
            s1_func_reg   <= s_data.func;
            s1_bin_reg    <= s_data.bin_id;
            s1_rating_reg <= s_data.rating;
            s1_hit_reg    <= 32'(s_data.bin_id) < NUM_BINS;
        end
        fwd_addr_reg <= ram_waddr;
        fwd_data_reg <= ram_wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (div_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (div_take) begin
            m_data_reg <= div_res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

[sv/gab_chk.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gab_chk: port-level checks for grouped_average_bins
// Reset behavior, read stall, result field consistency, output beat hold.
// ----------------------------------------------------------------------------
module gab_chk (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_valid,
    input wire logic          s_ready,
    input wire gab_pkg::in_t  s_data,
    input wire logic          m_valid,
    input wire logic          m_ready,
    input wire gab_pkg::out_t m_data
);
    import gab_pkg::*;

    // clearing pass holds off input right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("ports active right after reset");

    // a read beat holds off the next beat while the divider runs
    a_read_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.func == FUNC_READ |=> !s_ready)
        else $error("beat accepted right behind a read");

    a_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.nonempty == (m_data.sample_count != '0))
                 && (!m_data.saturated || m_data.nonempty)
                 && (m_data.nonempty || m_data.average == '0))
        else $error("result flags disagree with count");

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped or changed while stalled");

endmodule

bind grouped_average_bins gab_chk u_gab_chk (.*);
`default_nettype wire

[tb/gab_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gab_checker: bin table predictor and result comparator
// Tracks every accepted add/read beat on the input channel in a shadow bin
// table, queues the average each read should return, and compares the result
// channel against that queue field by field.
// ----------------------------------------------------------------------------
module gab_checker (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    input  wire logic          s_ready,
    input  wire gab_pkg::in_t  s_data,
    input  wire logic          m_valid,
    input  wire logic          m_ready,
    input  wire gab_pkg::out_t m_data,
    output int unsigned        mismatches,
    output int unsigned        reads_in_flight,
    output int unsigned        add_beats,
    output int unsigned        read_beats,
    output int unsigned        saturated_reads
);
    timeunit 1ns;
    timeprecision 1ps;

    import gab_pkg::*;

    logic [COUNT_W-1:0] shadow_count [NUM_BINS];
    logic [SUM_W-1:0]   shadow_sum   [NUM_BINS];
    out_t               pending_averages [$];

    int unsigned err_total;
    int unsigned adds_seen;
    int unsigned reads_seen;
    int unsigned sat_seen;

    function automatic out_t averaged_bin(input logic [BIN_ID_W-1:0] key);
        out_t               r;
        logic [COUNT_W-1:0] cnt;
        logic [SUM_W-1:0]   total;
        longint unsigned    num;
        longint unsigned    quo;
        cnt   = '0;
        total = '0;
        quo   = 0;
        if (int'(key) < NUM_BINS) begin
            cnt   = shadow_count[key];
            total = shadow_sum[key];
        end
        if (cnt != '0) begin
            num = total;
            num = num << FRAC_W;
            quo = num / cnt;
            if (quo > AVG_MAX) begin
                quo = AVG_MAX;
            end
        end
        r.read_bin     = key;
        r.average      = quo[AVG_W-1:0];
        r.sample_count = cnt;
        r.nonempty     = (cnt != '0);
        r.saturated    = (cnt == COUNT_MAX);
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            err_total++;
        end
    endtask

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            foreach (shadow_count[i]) begin
                shadow_count[i] = '0;
                shadow_sum[i]   = '0;
            end
            pending_averages.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_averages.size() == 0) begin
                    $error("result beat for bin %0d with no read outstanding", m_data.read_bin);
                    err_total++;
                end else begin
                    want = pending_averages.pop_front();
                    check_field("read_bin",     want.read_bin,     m_data.read_bin);
                    check_field("average",      want.average,      m_data.average);
                    check_field("sample_count", want.sample_count, m_data.sample_count);
                    check_field("nonempty",     want.nonempty,     m_data.nonempty);
                    check_field("saturated",    want.saturated,    m_data.saturated);
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.func == FUNC_ADD) begin
                    adds_seen++;
                    // full bins drop the sample, sum included
                    if (int'(s_data.bin_id) < NUM_BINS &&
                        shadow_count[s_data.bin_id] != COUNT_MAX) begin
                        shadow_count[s_data.bin_id] = shadow_count[s_data.bin_id] + 1'b1;
                        shadow_sum[s_data.bin_id]   = shadow_sum[s_data.bin_id] + s_data.rating;
                    end
                end else begin
                    reads_seen++;
                    want = averaged_bin(s_data.bin_id);
                    if (want.saturated) begin
                        sat_seen++;
                    end
                    pending_averages.push_back(want);
                end
            end
        end
        mismatches      <= err_total;
        reads_in_flight <= pending_averages.size();
        add_beats       <= adds_seen;
        read_beats      <= reads_seen;
        saturated_reads <= sat_seen;
    end

endmodule
`default_nettype wire

[tb/grouped_average_bins_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grouped_average_bins_tb: stimulus and verdict for the grouped average bins
// Directed corner beats, then random add/read traffic over a few hot bins
// and the whole key range, with random idles on both channels and one long
// result stall. Checking is done by gab_checker.
// ----------------------------------------------------------------------------
module grouped_average_bins_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gab_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int IDLE_PCT      = 32;
    localparam int RX_HOLD       = 300;
    localparam int QUIET_LIMIT   = 20000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_BEATS  = 1300;
    localparam int STEADY_BEATS  = 300;
    localparam int HOT_BINS      = 8;

    logic  aclk    = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    in_t   s_data  = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    out_t  m_data;

    int unsigned mismatches;
    int unsigned reads_in_flight;
    int unsigned add_beats;
    int unsigned read_beats;
    int unsigned saturated_reads;

    bit rx_steady   = 1'b0;
    bit rx_hold_req = 1'b0;

    int unsigned quiet_cycles = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    grouped_average_bins dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    gab_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .mismatches      (mismatches),
        .reads_in_flight (reads_in_flight),
        .add_beats       (add_beats),
        .read_beats      (read_beats),
        .saturated_reads (saturated_reads)
    );

    // Any cycle without a beat on either channel counts toward the limit.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: random backpressure, steady mode, and one long hold-off.
    initial begin : result_sink
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (RX_HOLD) @(posedge aclk);
            end else if (rx_steady) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99, 0) >= IDLE_PCT);
            end
        end
    end

    task automatic send_beat(input func_t op, input logic [BIN_ID_W-1:0] key,
                             input logic [RATING_W-1:0] rating, input bit allow_idle);
        in_t beat;
        beat.func   = op;
        beat.bin_id = key;
        beat.rating = rating;
        if (allow_idle) begin
            while ($urandom_range(99, 0) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
    endtask

    initial begin : stimulus
        logic [BIN_ID_W-1:0] hot_keys [HOT_BINS];
        logic [BIN_ID_W-1:0] key;
        func_t               op;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // empty bins at both ends of the key range, rating ignored on reads
        send_beat(FUNC_READ, 11'h000, 4'hF, 1'b1);
        send_beat(FUNC_READ, 11'h7FF, 4'hF, 1'b1);
        // min and max ratings into bin 0
        send_beat(FUNC_ADD,  11'h000, 4'h0, 1'b1);
        send_beat(FUNC_ADD,  11'h000, 4'hF, 1'b1);
        send_beat(FUNC_READ, 11'h000, 4'h0, 1'b1);
        // top bin at the largest average
        send_beat(FUNC_ADD,  11'h7FF, 4'hF, 1'b1);
        send_beat(FUNC_ADD,  11'h7FF, 4'hF, 1'b0);
        send_beat(FUNC_ADD,  11'h7FF, 4'hF, 1'b0);
        send_beat(FUNC_READ, 11'h7FF, 4'h0, 1'b1);
        // 5/3 truncates
        send_beat(FUNC_ADD,  11'h005, 4'h1, 1'b1);
        send_beat(FUNC_ADD,  11'h005, 4'h2, 1'b1);
        send_beat(FUNC_ADD,  11'h005, 4'h2, 1'b1);
        send_beat(FUNC_READ, 11'h005, 4'h0, 1'b1);
        // back-to-back adds and read on one bin exercise write forwarding
        send_beat(FUNC_ADD,  11'h009, 4'h7, 1'b1);
        send_beat(FUNC_ADD,  11'h009, 4'h8, 1'b0);
        send_beat(FUNC_READ, 11'h009, 4'h5, 1'b0);
        // alternating key bit patterns
        send_beat(FUNC_ADD,  11'h555, 4'hA, 1'b1);
        send_beat(FUNC_READ, 11'h2AA, 4'h5, 1'b0);
        send_beat(FUNC_READ, 11'h555, 4'hA, 1'b1);

        // random traffic; stall the result side early so the block backs up
        rx_hold_req = 1'b1;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 250 == 0) begin
                foreach (hot_keys[h]) hot_keys[h] = 11'($urandom_range(NUM_BINS - 1, 0));
            end
            if (n == RANDOM_BEATS - STEADY_BEATS) begin
                rx_steady = 1'b1;
            end
            if ($urandom_range(99, 0) < 70) begin
                key = hot_keys[$urandom_range(HOT_BINS - 1, 0)];
            end else begin
                key = 11'($urandom_range(NUM_BINS - 1, 0));
            end
            op = ($urandom_range(99, 0) < 55) ? FUNC_ADD : FUNC_READ;
            send_beat(op, key, 4'($urandom_range(15, 0)),
                      n < RANDOM_BEATS - STEADY_BEATS);
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (reads_in_flight != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d add beats and %0d read beats, %0d of them on a full bin,",
                 add_beats, read_beats, saturated_reads);
        $display("with random idles on both channels and one long result-side stall.");
        if (mismatches == 0 && reads_in_flight == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
